[rtl/sspp_pkg.sv]
// ----------------------------------------------------------------------------
// Servo status packet parser package
// Shared types, codes and constants for the status packet parser.
// ----------------------------------------------------------------------------
package sspp_pkg;

    localparam int MAX_LENGTH = 20;
    localparam int MIN_LENGTH = 4;
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam int BODY_LEN_W = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_W = 3;
    localparam logic ADDR_SERVO_ID = 1'b0;
    localparam logic [7:0] SERVO_ID_RESET = 8'd1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_LENGTH   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_HUNT1 = 5'b00001,
        PH_HUNT2 = 5'b00010,
        PH_ID    = 5'b00100,
        PH_LEN   = 5'b01000,
        PH_BODY  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [15:0] position;
        logic [7:0]  fault_byte;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

endpackage

[rtl/sspp_front.sv]
// ----------------------------------------------------------------------------
// Status packet parser front end
// Takes received bytes, tracks the packet framing and sum, and pushes results.
// ----------------------------------------------------------------------------
module sspp_front
    import sspp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  servo_id,
    output logic        push,
    output result_t     result
);

    phase_t                phase_reg, phase_next;
    logic [BODY_LEN_W-1:0] body_length_reg, body_length_next;
    logic [BODY_LEN_W-1:0] body_count_reg, body_count_next;
    logic [7:0]            running_sum_reg, running_sum_next;
    logic [7:0]            fault_hold_reg, fault_hold_next;
    logic [7:0]            position_low_reg, position_low_next;
    logic [7:0]            position_high_reg, position_high_next;
    logic [BODY_LEN_W:0]   count_inc;

    assign count_inc = {1'b0, body_count_reg} + {{BODY_LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next         = phase_reg;
        body_length_next   = body_length_reg;
        body_count_next    = body_count_reg;
        running_sum_next   = running_sum_reg;
        fault_hold_next    = fault_hold_reg;
        position_low_next  = position_low_reg;
        position_high_next = position_high_reg;
        push               = 1'b0;
        result.position    = 16'd0;
        result.fault_byte  = 8'd0;
        result.status      = ST_OK;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT2:
                begin
                    phase_next = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
                end
                PH_ID:
                begin
                    if (rx_byte == servo_id)
                    begin
                        running_sum_next = rx_byte;
                        phase_next       = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LEN:
                begin
                    if ((rx_byte < 8'(MIN_LENGTH)) || (rx_byte > 8'(MAX_LENGTH)))
                    begin
                        phase_next    = PH_HUNT1;
                        push          = 1'b1;
                        result.status = ST_LENGTH;
                    end
                    else
                    begin
                        body_length_next   = rx_byte[BODY_LEN_W-1:0];
                        body_count_next    = '0;
                        running_sum_next   = running_sum_reg + rx_byte;
                        fault_hold_next    = 8'd0;
                        position_low_next  = 8'd0;
                        position_high_next = 8'd0;
                        phase_next         = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (count_inc >= {1'b0, body_length_reg})
                    begin
                        phase_next = PH_HUNT1;
                        push       = 1'b1;
                        if (rx_byte == ~running_sum_reg)
                        begin
                            result.position   = {position_high_reg, position_low_reg};
                            result.fault_byte = fault_hold_reg;
                            result.status     = ST_OK;
                        end
                        else
                        begin
                            result.status = ST_CHECKSUM;
                        end
                    end
                    else
                    begin
                        case (body_count_reg)
                            BODY_LEN_W'(0): fault_hold_next    = rx_byte;
                            BODY_LEN_W'(1): position_low_next  = rx_byte;
                            BODY_LEN_W'(2): position_high_next = rx_byte;
                            default: ;
                        endcase
                        running_sum_next = running_sum_reg + rx_byte;
                        body_count_next  = count_inc[BODY_LEN_W-1:0];
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT1;
            body_length_reg   <= '0;
            body_count_reg    <= '0;
            running_sum_reg   <= 8'd0;
            fault_hold_reg    <= 8'd0;
            position_low_reg  <= 8'd0;
            position_high_reg <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            body_length_reg   <= body_length_next;
            body_count_reg    <= body_count_next;
            running_sum_reg   <= running_sum_next;
            fault_hold_reg    <= fault_hold_next;
            position_low_reg  <= position_low_next;
            position_high_reg <= position_high_next;
        end
    end

endmodule

[rtl/sspp_queue.sv]
// ----------------------------------------------------------------------------
// Status packet parser result queue
// Short first-in first-out queue of results between the front and back ends.
// ----------------------------------------------------------------------------
module sspp_queue
    import sspp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_t       push_data,
    input  logic          pop,
    output result_t       head,
    output queue_status_t qstat
);

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    assign qstat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;
    assign head        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/sspp_back.sv]
// ----------------------------------------------------------------------------
// Status packet parser back end
// Output register that presents queued results to the receiver.
// ----------------------------------------------------------------------------
module sspp_back
    import sspp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  result_t     q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] position,
    output logic [7:0]  fault_byte,
    output logic [1:0]  status
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign q_pop      = !q_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_head;
        end
    end

    assign out_valid  = valid_reg;
    assign position   = data_reg.position;
    assign fault_byte = data_reg.fault_byte;
    assign status     = data_reg.status;

endmodule

[rtl/servo_status_packet_parser.sv]
// ----------------------------------------------------------------------------
// Servo status packet parser
// Frames protocol 1 status packets from a byte stream and reports their fields.
// ----------------------------------------------------------------------------
// Received bus bytes enter on the input channel (rx_byte, in_valid, in_ready),
// one transfer per byte. The parser looks for two 0xFF header bytes, the
// configured servo id and a length byte, then sums the body and checks the
// inverted checksum. Each complete packet, and each bad length byte, gives one
// transfer on the output channel (position, fault_byte, status, out_valid,
// out_ready). A byte may be taken in every cycle; the front end updates its
// state on each accepted byte. A result reaches the outputs through a two-entry
// queue and then an output register. While the receiver stalls, results collect
// in the queue; once the queue is full, in_ready falls until the output register
// drains. The servo id register is written and read through the APB port at
// address zero. Reset returns the parser to the header hunt, empties the queue
// and sets the servo id to one.
// ----------------------------------------------------------------------------
module servo_status_packet_parser
    import sspp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic [7:0]            rx_byte,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic [15:0]           position,
    output logic [7:0]            fault_byte,
    output logic [1:0]            status,
    output logic                  out_valid,
    input  logic                  out_ready
);

    logic [7:0]    servo_id_reg;
    logic          cfg_write;
    logic          accept;
    logic          push;
    result_t       push_data;
    logic          q_pop;
    result_t       q_head;
    queue_status_t qstat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == ADDR_SERVO_ID);
    assign prdata    = (paddr[APB_ADDR_W-1] == ADDR_SERVO_ID) ? {24'd0, servo_id_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg <= SERVO_ID_RESET;
        end
        else if (cfg_write)
        begin
            servo_id_reg <= pwdata[7:0];
        end
    end

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    sspp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .servo_id (servo_id_reg),
        .push     (push),
        .result   (push_data)
    );

    sspp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (qstat)
    );

    sspp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (qstat.empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .fault_byte (fault_byte),
        .status     (status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("Result queue holds more entries than its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("Result pushed while the queue is full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((position == 16'd0) && (fault_byte == 8'd0)))
        else $error("Failed result carries non-zero fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_OK) || (status == ST_CHECKSUM) || (status == ST_LENGTH)))
        else $error("Result carries an undefined status code.");

endmodule
